FILE: hw/rtl/iaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_pkg
// Shared types, codes and sizes of the address allowlist filter.
// ----------------------------------------------------------------------------
package iaf_pkg;

	// Learned address table
	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W     = 1 + 64 + 64;

	// Configuration port
	localparam int  PADDR_W         = 3;
	localparam logic CFG_IDX_ENFORCE = 1'b0;

	// Request action codes
	localparam logic ACT_LEARN = 1'b0;
	localparam logic ACT_CHECK = 1'b1;

	// Address family codes
	localparam logic [1:0] FAM_UNIX  = 2'd0;
	localparam logic [1:0] FAM_V4    = 2'd1;
	localparam logic [1:0] FAM_V6    = 2'd2;
	localparam logic [1:0] FAM_OTHER = 2'd3;

	// Allow reason codes
	localparam logic [2:0] WHY_DENY    = 3'd0;
	localparam logic [2:0] WHY_DEFAULT = 3'd1;
	localparam logic [2:0] WHY_LOOP    = 3'd2;
	localparam logic [2:0] WHY_PRIVATE = 3'd3;
	localparam logic [2:0] WHY_TABLE   = 3'd4;

	// Learn status codes
	localparam logic [1:0] LS_ADDED   = 2'd0;
	localparam logic [1:0] LS_PRESENT = 2'd1;
	localparam logic [1:0] LS_FULL    = 2'd2;
	localparam logic [1:0] LS_NONE    = 2'd3;

	// Fixed address ranges
	localparam logic [7:0]  V4_LOOP_NET   = 8'd127;
	localparam logic [7:0]  V4_PRIV_A     = 8'd10;
	localparam logic [11:0] V4_PRIV_B     = 12'hAC1;
	localparam logic [15:0] V4_PRIV_C     = 16'hC0A8;
	localparam logic [15:0] V4_LINK_LOCAL = 16'hA9FE;
	localparam logic [9:0]  V6_LINK_LOCAL = 10'h3FA;

	typedef struct packed {
		logic        action;
		logic [1:0]  addr_family;
		logic [63:0] address_high;
		logic [63:0] address_low;
	} req_t;

	typedef struct packed {
		logic       allowed;
		logic [2:0] allow_reason;
		logic [1:0] learn_status;
	} res_t;

	// Controller to datapath
	typedef struct packed {
		logic load_req;
		logic scan_run;
		logic wr_en;
		logic out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_scan;
		logic scan_done;
		logic add;
		logic out_free;
	} stat_t;

endpackage

FILE: hw/rtl/iaf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_req_if / iaf_res_if
// Valid/ready channels for filter requests and results.
// ----------------------------------------------------------------------------
interface iaf_req_if;
	logic          valid;
	logic          ready;
	iaf_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface iaf_res_if;
	logic          valid;
	logic          ready;
	iaf_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/iaf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module iaf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/iaf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_ctrl
// Request sequencer: accept, classify, table scan, result and learn write.
// ----------------------------------------------------------------------------
module iaf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  iaf_pkg::stat_t st,
	output iaf_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;

	assign req_ready = ready_q;
	assign accept    = req_valid && ready_q;

	// Commands to the datapath
	always_comb begin
		cmd.load_req = accept;
		cmd.scan_run = (state_q == S_SCAN);
		cmd.out_load = (state_q == S_FINISH) && st.out_free;
		cmd.wr_en    = (state_q == S_FINISH) && st.out_free && st.add;
	end

	// State and ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECIDE;
						ready_q <= 1'b0;
					end
				end
				S_DECIDE: begin
					state_q <= st.need_scan ? S_SCAN : S_FINISH;
				end
				S_SCAN: begin
					if (st.scan_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					// hold until the result register is free
					if (st.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/iaf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_dp
// Request register, range checks, learned table with scan and result register.
// ----------------------------------------------------------------------------
module iaf_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           enforce,
	input  iaf_pkg::req_t  req_data,
	input  iaf_pkg::cmd_t  cmd,
	output iaf_pkg::stat_t st,
	output logic           res_valid,
	input  logic           res_ready,
	output iaf_pkg::res_t  res_data
);

	logic                        act_q;
	logic [1:0]                  fam_q;
	logic [63:0]                 hi_q;
	logic [63:0]                 lo_q;
	logic [iaf_pkg::CNT_W-1:0]   count_q;
	logic [iaf_pkg::CNT_W-1:0]   issue_q;
	logic                        rd_pend_s1;
	logic                        found_q;
	logic                        out_valid_q;
	iaf_pkg::res_t               out_q;

	logic                        is_v4;
	logic                        is_v6;
	logic                        learn;
	logic                        learn_active;
	logic                        chk_default;
	logic                        chk_loop;
	logic                        chk_priv;
	logic [31:0]                 v4a;
	logic                        full;
	logic                        rd_en;
	logic                        hit;
	logic [iaf_pkg::ENTRY_W-1:0] key;
	logic [iaf_pkg::ENTRY_W-1:0] rd_data;
	iaf_pkg::res_t               res_next;

	// Capture request; IPv4 keeps only the low 32 bits
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			act_q <= req_data.action;
			fam_q <= req_data.addr_family;
			if (req_data.addr_family == iaf_pkg::FAM_V4) begin
				hi_q <= 64'd0;
				lo_q <= {32'd0, req_data.address_low[31:0]};
			end else begin
				hi_q <= req_data.address_high;
				lo_q <= req_data.address_low;
			end
		end
	end

	// Classify the held request
	always_comb begin
		is_v4        = (fam_q == iaf_pkg::FAM_V4);
		is_v6        = (fam_q == iaf_pkg::FAM_V6);
		learn        = (act_q == iaf_pkg::ACT_LEARN);
		learn_active = enforce && (is_v4 || is_v6);
		v4a          = lo_q[31:0];
		chk_default  = !enforce || (fam_q == iaf_pkg::FAM_UNIX) ||
			(fam_q == iaf_pkg::FAM_OTHER);
		chk_loop     = is_v4 ? ((v4a[31:24] == iaf_pkg::V4_LOOP_NET) || (v4a == 32'd0))
			: ((hi_q == 64'd0) && (lo_q[63:1] == 63'd0));
		chk_priv     = is_v4 ? ((v4a[31:24] == iaf_pkg::V4_PRIV_A) ||
			(v4a[31:20] == iaf_pkg::V4_PRIV_B) ||
			(v4a[31:16] == iaf_pkg::V4_PRIV_C) ||
			(v4a[31:16] == iaf_pkg::V4_LINK_LOCAL))
			: (hi_q[63:54] == iaf_pkg::V6_LINK_LOCAL);
		full         = (count_q == iaf_pkg::CNT_W'(iaf_pkg::TABLE_DEPTH));
		key          = {is_v6, hi_q, lo_q};
	end

	// Scan: read one entry a cycle, compare it in the cycle after the read
	assign rd_en = cmd.scan_run && (issue_q != count_q);
	assign hit   = rd_pend_s1 && (rd_data == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q    <= '0;
			rd_pend_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else if (cmd.load_req) begin
			issue_q    <= '0;
			rd_pend_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_en;
			if (rd_en) begin
				issue_q <= issue_q + 1'b1;
			end
			if (hit) begin
				found_q <= 1'b1;
			end
		end
	end

	iaf_ram #(
		.WIDTH(iaf_pkg::ENTRY_W),
		.DEPTH(iaf_pkg::TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(count_q[iaf_pkg::ADDR_W-1:0]),
		.wr_data(key),
		.rd_en  (rd_en),
		.rd_addr(issue_q[iaf_pkg::ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	// Fill count of the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.wr_en) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Result of the finished request
	always_comb begin
		res_next.allowed      = 1'b0;
		res_next.allow_reason = iaf_pkg::WHY_DENY;
		res_next.learn_status = iaf_pkg::LS_NONE;
		if (learn) begin
			if (!learn_active) begin
				res_next.learn_status = iaf_pkg::LS_NONE;
			end else if (found_q) begin
				res_next.learn_status = iaf_pkg::LS_PRESENT;
			end else if (full) begin
				res_next.learn_status = iaf_pkg::LS_FULL;
			end else begin
				res_next.learn_status = iaf_pkg::LS_ADDED;
			end
		end else begin
			priority if (chk_default) begin
				res_next.allow_reason = iaf_pkg::WHY_DEFAULT;
			end else if (chk_loop) begin
				res_next.allow_reason = iaf_pkg::WHY_LOOP;
			end else if (chk_priv) begin
				res_next.allow_reason = iaf_pkg::WHY_PRIVATE;
			end else if (found_q) begin
				res_next.allow_reason = iaf_pkg::WHY_TABLE;
			end else begin
				res_next.allow_reason = iaf_pkg::WHY_DENY;
			end
			res_next.allowed = (res_next.allow_reason != iaf_pkg::WHY_DENY);
		end
	end

	// Status to the controller
	always_comb begin
		st.need_scan = learn ? learn_active : (!chk_default && !chk_loop && !chk_priv);
		st.scan_done = hit || !rd_en;
		st.add       = learn && learn_active && !found_q && !full;
		st.out_free  = !out_valid_q || res_ready;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= res_next;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

endmodule

FILE: hw/rtl/ip_allowlist_filter_unit.sv
`timescale 1ns / 1ps
// Flow: a request is registered at its transfer and classified in S_DECIDE; only
//   when a table lookup is needed does S_SCAN search the learned table, stopping
//   at a hit or after the last entry. The result is then loaded in S_FINISH.
// Throughput: one request at a time; the next can be taken in the cycle after the
//   result is loaded. The table scan reads one entry per cycle. A pending result does not block the next request.
// Reset: arst_n clears the table fill count, the enforce register and control.
// ----------------------------------------------------------------------------
// ip_allowlist_filter_unit
// Connection allowlist filter with a learned address table and APB config.
// ----------------------------------------------------------------------------
module ip_allowlist_filter_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	iaf_req_if.sink                     req,
	iaf_res_if.source                   res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [iaf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	iaf_pkg::cmd_t  cmd;
	iaf_pkg::stat_t st;
	logic           enforce_q;
	logic           cfg_wr;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enforce_q <= 1'b0;
		end else if (cfg_wr && (paddr[2] == iaf_pkg::CFG_IDX_ENFORCE)) begin
			enforce_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == iaf_pkg::CFG_IDX_ENFORCE) ? {31'd0, enforce_q} : 32'd0;

	iaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	iaf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.enforce  (enforce_q),
		.req_data (req.data),
		.cmd      (cmd),
		.st       (st),
		.res_valid(res.valid),
		.res_ready(res.ready),
		.res_data (res.data)
	);

	// One request in flight at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in flight");

	// Table writes happen only together with the result load
	a_write_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> cmd.out_load)
		else $error("table write without result load");

	// Never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!res.valid || res.ready))
		else $error("result register overwritten");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the connection allowlist filter.
// Drives learn and check requests through the valid/ready request channel,
// predicts each verdict with a behavioral table of learned addresses, and
// compares every result transfer field by field. The enforce register is
// written and read back over APB between traffic phases.
// ----------------------------------------------------------------------------
module tb;
	import iaf_pkg::*;

	localparam logic [PADDR_W-1:0] ENFORCE_ADDR = PADDR_W'(4 * CFG_IDX_ENFORCE);

	typedef struct packed {
		logic        v6;
		logic [63:0] hi;
		logic [63:0] lo;
	} learned_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr  = '0;
	logic [31:0]       pwdata  = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              rx_ready = 1'b0;

	iaf_req_if req_ch ();
	iaf_res_if res_ch ();

	// Model state: learned addresses, enforce bit, verdicts in flight
	learned_t learned_addrs[$];
	res_t     pending_verdicts[$];
	logic     enforce_on  = 1'b0;
	logic     idle_en     = 1'b1;
	int       hold_left   = 0;
	int       stall_left  = 0;
	int       error_count = 0;
	int       results_seen = 0;

	ip_allowlist_filter_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	assign res_ch.ready = rx_ready;

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= 200) begin
			$display("[%0t] MISMATCH %s", $time, what);
		end
	endtask

	// Compute the verdict for one request and update the learned table
	function automatic res_t filter_verdict(input req_t r);
		res_t        v;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        v6;
		logic        known;
		logic        hit;
		v.allowed      = 1'b0;
		v.allow_reason = WHY_DENY;
		v.learn_status = LS_NONE;
		v6    = (r.addr_family == FAM_V6);
		known = (r.addr_family == FAM_V4) || (r.addr_family == FAM_V6);
		hi    = r.address_high;
		lo    = r.address_low;
		// IPv4 keeps only the low word
		if (r.addr_family == FAM_V4) begin
			hi        = '0;
			lo[63:32] = '0;
		end
		hit = 1'b0;
		foreach (learned_addrs[k]) begin
			if (learned_addrs[k].v6 == v6 && learned_addrs[k].hi == hi &&
					learned_addrs[k].lo == lo) begin
				hit = 1'b1;
			end
		end
		if (r.action == ACT_LEARN) begin
			if (enforce_on && known) begin
				if (hit) begin
					v.learn_status = LS_PRESENT;
				end else if (learned_addrs.size() >= TABLE_DEPTH) begin
					v.learn_status = LS_FULL;
				end else begin
					learned_addrs.push_back('{v6, hi, lo});
					v.learn_status = LS_ADDED;
				end
			end
		end else begin
			if (!enforce_on || !known) begin
				v.allow_reason = WHY_DEFAULT;
			end else if (!v6) begin
				if (lo[31:24] == V4_LOOP_NET || lo[31:0] == 32'd0) begin
					v.allow_reason = WHY_LOOP;
				end else if (lo[31:24] == V4_PRIV_A || lo[31:20] == V4_PRIV_B ||
						lo[31:16] == V4_PRIV_C || lo[31:16] == V4_LINK_LOCAL) begin
					v.allow_reason = WHY_PRIVATE;
				end else if (hit) begin
					v.allow_reason = WHY_TABLE;
				end
			end else begin
				if (hi == 64'd0 && lo <= 64'd1) begin
					v.allow_reason = WHY_LOOP;
				end else if (hi[63:54] == V6_LINK_LOCAL) begin
					v.allow_reason = WHY_PRIVATE;
				end else if (hit) begin
					v.allow_reason = WHY_TABLE;
				end
			end
			v.allowed = (v.allow_reason != WHY_DENY);
		end
		return v;
	endfunction

	function automatic req_t make_req(input logic act, input logic [1:0] fam,
			input logic [63:0] hi, input logic [63:0] lo);
		req_t r;
		r.action       = act;
		r.addr_family  = fam;
		r.address_high = hi;
		r.address_low  = lo;
		return r;
	endfunction

	// Random request biased toward range edges and known table entries
	function automatic req_t random_request();
		req_t        r;
		learned_t    e;
		int          cls;
		logic [31:0] a;
		r.action       = ($urandom_range(0, 99) < 35) ? ACT_LEARN : ACT_CHECK;
		r.address_high = {$urandom, $urandom};
		r.address_low  = {$urandom, $urandom};
		e = '0;
		if (learned_addrs.size() > 0) begin
			e = learned_addrs[$urandom_range(0, learned_addrs.size() - 1)];
		end
		cls = $urandom_range(0, 9);
		case ($urandom_range(0, 9))
			0: r.addr_family = FAM_UNIX;
			1: r.addr_family = FAM_OTHER;
			2, 3, 4, 5: r.addr_family = FAM_V4;
			default: r.addr_family = FAM_V6;
		endcase
		if (r.addr_family == FAM_V4) begin
			a = r.address_low[31:0];
			case (cls)
				0: a[31:24] = V4_LOOP_NET;
				1: a = '0;
				2: a[31:24] = V4_PRIV_A;
				3: a[31:20] = V4_PRIV_B;
				4: a[31:20] = ($urandom_range(0, 1) != 0) ? 12'hAC0 : 12'hAC2;
				5: a[31:16] = ($urandom_range(0, 1) != 0) ? V4_PRIV_C : V4_LINK_LOCAL;
				6, 7: a = e.lo[31:0];
				default: a = 32'h2C00_0000 | $urandom_range(0, 47);
			endcase
			r.address_low[31:0] = a;
		end else if (r.addr_family == FAM_V6) begin
			case (cls)
				0: begin
					r.address_high = '0;
					r.address_low  = 64'($urandom_range(0, 2));
				end
				1: r.address_high[63:54] = V6_LINK_LOCAL;
				2: r.address_high[63:54] = ($urandom_range(0, 1) != 0) ? 10'h3F9 : 10'h3FB;
				3: begin
					r.address_high = '0;
					r.address_low  = {32'd0, e.lo[31:0]};
				end
				4, 5, 6: begin
					r.address_high = e.hi;
					r.address_low  = e.lo;
				end
				default: begin
					r.address_high = 64'h2001_0DB8_0000_0000;
					r.address_low  = 64'($urandom_range(0, 47));
				end
			endcase
		end
		return r;
	endfunction

	// Offer one request and log its verdict at the transfer
	task automatic send_request(input req_t r);
		int gap;
		gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.data  = r;
		do @(posedge clk); while (!req_ch.ready);
		pending_verdicts.push_back(filter_verdict(r));
		@(negedge clk);
	endtask

	// Drop valid and hold until every verdict has come back
	task automatic wait_for_results();
		req_ch.valid = 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
	endtask

	task automatic read_enforce_check();
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = ENFORCE_ADDR;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {31'd0, enforce_on}) begin
			report_mismatch($sformatf("enforce readback: got %h expected %h",
				prdata, {31'd0, enforce_on}));
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Write the enforce register while the block is idle, then read it back
	task automatic configure_enforce(input logic [31:0] word);
		wait_for_results();
		repeat (4) @(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ENFORCE_ADDR;
		pwdata  = word;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		enforce_on = word[0];
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		read_enforce_check();
	endtask

	// Reset value, enforcement off, and register extremes
	task automatic test_reset_defaults();
		read_enforce_check();
		send_request(make_req(ACT_CHECK, FAM_V4, '0, 64'h0000_0000_0808_0808));
		send_request(make_req(ACT_LEARN, FAM_V4, '0, 64'h0000_0000_0808_0808));
		send_request(make_req(ACT_CHECK, FAM_V6, 64'h2001_0DB8_0000_0000, 64'd5));
		send_request(make_req(ACT_LEARN, FAM_V6, 64'h2001_0DB8_0000_0000, 64'd5));
		send_request(make_req(ACT_LEARN, FAM_UNIX, '1, '1));
		send_request(make_req(ACT_CHECK, FAM_OTHER, '1, '1));
		configure_enforce(32'hFFFF_FFFF);
		send_request(make_req(ACT_CHECK, FAM_V4, '0, 64'h0000_0000_0102_0304));
		configure_enforce(32'hFFFF_FFFE);
		send_request(make_req(ACT_CHECK, FAM_V4, '0, 64'h0000_0000_0102_0304));
		configure_enforce(32'h0000_0000);
	endtask

	// Fixed ranges, table hits, family separation and ignored learns
	task automatic test_directed_rules();
		configure_enforce(32'h0000_0001);
		send_request(make_req(ACT_CHECK, FAM_V4, '1, 64'hFFFF_FFFF_7F00_0001));
		send_request(make_req(ACT_CHECK, FAM_V4, '0, 64'h0000_0000_7FFF_FFFF));
		send_request(make_req(ACT_CHECK, FAM_V4, 64'hDEAD_BEEF_0000_0001,
			64'h1234_5678_0000_0000));
		send_request(make_req(ACT_CHECK, FAM_V4, '0, 64'h0000_0000_0AFF_FFFF));
		send_request(make_req(ACT_CHECK, FAM_V4, '0, 64'h0000_0000_AC10_0000));
		send_request(make_req(ACT_CHECK, FAM_V4, '0, 64'h0000_0000_AC1F_FFFF));
		send_request(make_req(ACT_CHECK, FAM_V4, '0, 64'h0000_0000_AC0F_FFFF));
		send_request(make_req(ACT_CHECK, FAM_V4, '0, 64'h0000_0000_AC20_0000));
		send_request(make_req(ACT_CHECK, FAM_V4, '0, 64'h0000_0000_C0A8_0101));
		send_request(make_req(ACT_CHECK, FAM_V4, '0, 64'h0000_0000_A9FE_0001));
		send_request(make_req(ACT_CHECK, FAM_V4, '1, '1));
		// Learn an address, repeat it with other upper bits, then hit it
		send_request(make_req(ACT_LEARN, FAM_V4, '1, 64'hFFFF_FFFF_0808_0808));
		send_request(make_req(ACT_LEARN, FAM_V4, '0, 64'h0000_0000_0808_0808));
		send_request(make_req(ACT_CHECK, FAM_V4, 64'h5555_AAAA_5555_AAAA,
			64'hAAAA_5555_0808_0808));
		// Same bits in the other family must not match
		send_request(make_req(ACT_CHECK, FAM_V6, '0, 64'h0000_0000_0808_0808));
		send_request(make_req(ACT_CHECK, FAM_V6, '0, 64'd1));
		send_request(make_req(ACT_CHECK, FAM_V6, '0, '0));
		send_request(make_req(ACT_CHECK, FAM_V6, '0, 64'd2));
		send_request(make_req(ACT_CHECK, FAM_V6, 64'hFE80_0000_0000_0000, '0));
		send_request(make_req(ACT_CHECK, FAM_V6, 64'hFEBF_FFFF_FFFF_FFFF, '1));
		send_request(make_req(ACT_CHECK, FAM_V6, 64'hFEC0_0000_0000_0000, '0));
		send_request(make_req(ACT_LEARN, FAM_V6, '1, '1));
		send_request(make_req(ACT_CHECK, FAM_V6, '1, '1));
		send_request(make_req(ACT_LEARN, FAM_OTHER, '0, 64'd7));
		send_request(make_req(ACT_CHECK, FAM_UNIX, '0, '0));
	endtask

	// Random phases with enforce changes, a long sink hold-off and a source pause
	task automatic test_random_traffic();
		int          ph;
		int          n;
		logic [31:0] word;
		for (ph = 0; ph < 6; ph++) begin
			word    = $urandom;
			word[0] = (ph != 1 && ph != 4);
			configure_enforce(word);
			idle_en = (ph != 3 && ph != 5);
			for (n = 0; n < 95; n++) begin
				if (ph == 2 && n == 30) begin
					hold_left = 400;
				end
				if (ph == 4 && n == 50) begin
					wait_for_results();
				end
				send_request(random_request());
			end
		end
	endtask

	// Result sink: random stall bursts plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rx_ready  = 1'b0;
			hold_left = hold_left - 1;
		end else if (stall_left > 0) begin
			rx_ready   = 1'b0;
			stall_left = stall_left - 1;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			rx_ready   = 1'b0;
			stall_left = $urandom_range(0, 9);
		end else begin
			rx_ready = 1'b1;
		end
	end

	// Compare each result transfer against the oldest predicted verdict
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing expected: %b/%0d/%0d",
					results_seen, res_ch.data.allowed, res_ch.data.allow_reason,
					res_ch.data.learn_status));
			end else begin
				want = pending_verdicts.pop_front();
				if (res_ch.data.allowed !== want.allowed) begin
					report_mismatch($sformatf("result %0d allowed: got %b expected %b",
						results_seen, res_ch.data.allowed, want.allowed));
				end
				if (res_ch.data.allow_reason !== want.allow_reason) begin
					report_mismatch($sformatf("result %0d allow_reason: got %0d expected %0d",
						results_seen, res_ch.data.allow_reason, want.allow_reason));
				end
				if (res_ch.data.learn_status !== want.learn_status) begin
					report_mismatch($sformatf("result %0d learn_status: got %0d expected %0d",
						results_seen, res_ch.data.learn_status, want.learn_status));
				end
			end
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_directed_rules();
		test_random_traffic();
		// Let any stray result surface before the verdict
		wait_for_results();
		repeat (TABLE_DEPTH + 8) @(negedge clk);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#200_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/iaf_pkg.sv
hw/rtl/iaf_if.sv
hw/rtl/iaf_ram.sv
hw/rtl/iaf_ctrl.sv
hw/rtl/iaf_dp.sv
hw/rtl/ip_allowlist_filter_unit.sv
verif/tb.sv
